>>> hdl/rmc_pkg.sv
`default_nettype none
package rmc_pkg;

  localparam logic [3:0] TOKEN_SAT = 4'd9;
  localparam logic [3:0] POS_SAT   = 4'd15;
  localparam logic [3:0] HDR_LEN   = 4'd6;
  localparam logic [3:0] TOK_HDR   = 4'd0;
  localparam logic [3:0] TOK_TIME  = 4'd1;
  localparam logic [3:0] TOK_FIX   = 4'd2;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_FIX_OK = 8'h41;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HEADER  = 2'd1,
    ST_FIX     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] field_id;
    logic [3:0] position;
    logic [7:0] field_char;
    status_t    status;
    logic       last;
  } result_t;

  // "$GPRMC"
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // kept characters per token, 0 when the token is not captured
  function automatic logic [3:0] tok_limit(input logic [3:0] tok);
    logic [3:0] l;
    case (tok)
      4'd1:    l = 4'd11;
      4'd3:    l = 4'd10;
      4'd4:    l = 4'd1;
      4'd5:    l = 4'd11;
      4'd6:    l = 4'd1;
      4'd7:    l = 4'd6;
      4'd8:    l = 4'd7;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic [2:0] tok_field(input logic [3:0] tok);
    logic [2:0] f;
    case (tok)
      4'd3:    f = 3'd1;
      4'd4:    f = 3'd2;
      4'd5:    f = 3'd3;
      4'd6:    f = 3'd4;
      4'd7:    f = 3'd5;
      4'd8:    f = 3'd6;
      default: f = 3'd0;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rmc_parser.sv
`default_nettype none
module rmc_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [7:0]       ch,
  input  wire logic             eos,
  output logic [1:0]            res_cnt,
  output rmc_pkg::result_t      res0,
  output rmc_pkg::result_t      res1
);

  logic [3:0]       tok_r, tok_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic             open_r, open_nxt;
  logic             mism_r, mism_nxt;
  rmc_pkg::status_t fail_r, fail_nxt;

  logic             is_comma;
  logic [3:0]       pos0;
  logic             mism0;
  logic             emit_char;
  logic [3:0]       tok1, pos1, tok2;
  logic             open1, mism1;
  rmc_pkg::status_t fail2;
  rmc_pkg::status_t st;
  logic [2:0]       st_fid;
  rmc_pkg::result_t char_res, stat_res;

  always_comb begin
    is_comma  = (ch == rmc_pkg::CH_COMMA);
    pos0      = open_r ? pos_r : 4'd0;
    mism0     = open_r & mism_r;
    emit_char = 1'b0;
    tok1      = tok_r;
    pos1      = pos_r;
    open1     = open_r;
    mism1     = mism_r;

    // character handling, commas leave the state for the close step
    if (!is_comma) begin
      open1 = 1'b1;
      mism1 = mism0;
      if (tok_r == rmc_pkg::TOK_HDR) begin
        if (pos0 >= rmc_pkg::HDR_LEN || ch != rmc_pkg::hdr_char(pos0[2:0])) begin
          mism1 = 1'b1;
        end
      end else if (tok_r == rmc_pkg::TOK_FIX) begin
        if (pos0 != 4'd0 || ch != rmc_pkg::CH_FIX_OK) begin
          mism1 = 1'b1;
        end
      end else if (fail_r == rmc_pkg::ST_OK && tok_r < rmc_pkg::TOKEN_SAT &&
                   pos0 < rmc_pkg::tok_limit(tok_r)) begin
        emit_char = 1'b1;
      end
      pos1 = (pos0 < rmc_pkg::POS_SAT) ? pos0 + 4'd1 : pos0;
    end

    // token close on a comma or at the end of the sentence
    tok2  = tok1;
    fail2 = fail_r;
    if ((is_comma || eos) && open1) begin
      if (fail_r == rmc_pkg::ST_OK) begin
        if (tok1 == rmc_pkg::TOK_HDR && (mism1 || pos1 != rmc_pkg::HDR_LEN)) begin
          fail2 = rmc_pkg::ST_HEADER;
        end else if (tok1 == rmc_pkg::TOK_FIX && (mism1 || pos1 != 4'd1)) begin
          fail2 = rmc_pkg::ST_FIX;
        end
      end
      if (tok1 < rmc_pkg::TOKEN_SAT) begin
        tok2 = tok1 + 4'd1;
      end
    end

    st     = rmc_pkg::ST_OK;
    st_fid = 3'd0;
    if (fail2 != rmc_pkg::ST_OK) begin
      st = fail2;
    end else if (tok2 == rmc_pkg::TOK_HDR) begin
      st = rmc_pkg::ST_HEADER;
    end else if (tok2 == rmc_pkg::TOK_TIME) begin
      st = rmc_pkg::ST_MISSING;
    end else if (tok2 == rmc_pkg::TOK_FIX) begin
      st = rmc_pkg::ST_FIX;
    end else if (tok2 < rmc_pkg::TOKEN_SAT) begin
      st     = rmc_pkg::ST_MISSING;
      st_fid = 3'(tok2 - 4'd2);
    end

    char_res.kind       = rmc_pkg::KIND_CHAR;
    char_res.field_id   = rmc_pkg::tok_field(tok_r);
    char_res.position   = pos0;
    char_res.field_char = ch;
    char_res.status     = rmc_pkg::ST_OK;
    char_res.last       = !eos;

    stat_res.kind       = rmc_pkg::KIND_STATUS;
    stat_res.field_id   = st_fid;
    stat_res.position   = 4'd0;
    stat_res.field_char = 8'h00;
    stat_res.status     = st;
    stat_res.last       = 1'b1;

    res0    = emit_char ? char_res : stat_res;
    res1    = stat_res;
    res_cnt = {1'b0, emit_char} + {1'b0, eos};
    if (!fire) begin
      res_cnt = 2'd0;
    end

    if (eos) begin
      tok_nxt  = 4'd0;
      pos_nxt  = 4'd0;
      open_nxt = 1'b0;
      mism_nxt = 1'b0;
      fail_nxt = rmc_pkg::ST_OK;
    end else begin
      tok_nxt  = tok2;
      pos_nxt  = pos1;
      open_nxt = open1 & !is_comma;
      mism_nxt = mism1;
      fail_nxt = fail2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 4'd0;
      pos_r  <= 4'd0;
      open_r <= 1'b0;
      mism_r <= 1'b0;
      fail_r <= rmc_pkg::ST_OK;
    end else if (fire) begin
      tok_r  <= tok_nxt;
      pos_r  <= pos_nxt;
      open_r <= open_nxt;
      mism_r <= mism_nxt;
      fail_r <= fail_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/rmc_res_fifo.sv
`default_nettype none
module rmc_res_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       push_cnt,
  input  wire rmc_pkg::result_t push0,
  input  wire rmc_pkg::result_t push1,
  output logic                  has_room,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output rmc_pkg::result_t      pop_data
);

  rmc_pkg::result_t mem_r [4];
  logic [1:0]       wr_r, wr_nxt;
  logic [1:0]       rd_r, rd_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             pop;

  // room for a two-beat burst whatever the read side does
  assign has_room  = (cnt_r <= 3'd2);
  assign pop_valid = (cnt_r != 3'd0);
  assign pop_data  = mem_r[rd_r];
  assign pop       = pop_valid & pop_ready;

  always_comb begin
    wr_nxt  = wr_r + push_cnt;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_r + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/nmea_rmc_field_extractor.sv
// RMC sentence field extractor.
// Slave side takes one sentence byte per beat in in_tdata, with in_tlast on
// the final byte. Master side gives one result per beat: out_tuser is the
// kind (0 field character, 1 sentence status), out_tlast marks the final
// result caused by an input byte, out_tdata carries field id, position,
// character and status.
// A byte is parsed in the cycle it is accepted; its results sit in a
// four-entry result queue and, if the queue was empty, the first shows on
// the master side the next cycle. A byte yields at most two results (a
// character and, on the last byte, the status).
// Throughput is one byte per cycle while the receiver keeps up; in_tready
// drops only when the queue holds three or more results.
// When the receiver stalls, out_tdata holds and the queue fills; the slave
// side keeps taking bytes until fewer than two queue entries are free.
// Reset (rst_n low, synchronous) empties the queue and returns the parser
// to the start of a sentence.
`default_nettype none
module nmea_rmc_field_extractor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [2:0] field_id, [6:3] position,
                                       // [14:7] field_char, [16:15] status
  output logic             out_tuser,  // [0] kind
  output logic             out_tlast
);

  logic             fire;
  logic [1:0]       res_cnt;
  rmc_pkg::result_t res0, res1, head;

  assign fire = in_tvalid & in_tready;

  rmc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .ch      (in_tdata),
    .eos     (in_tlast),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  rmc_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .has_room  (in_tready),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  assign out_tdata = {7'd0, head.status, head.field_char, head.position, head.field_id};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule
`default_nettype wire
